>>> rtl/first_fit_segment_allocator_core_macros.svh
// assertion macros for the allocator rtl
// no dependencies; included by first_fit_segment_allocator_core.sv, which carries assertions
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FFSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define FFSA_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFSA_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ffsa_pkg.sv
// types and codes for the first-fit segment allocator
// no dependencies
`timescale 1ns / 1ps

package ffsa_pkg;

   // request actions
   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_RESIZE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOFIT     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BADRESIZE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] offset;
      logic [31:0] length;
      logic [31:0] new_capacity;
   } ffsa_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] alloc_offset;
      logic [5:0]  free_segments;
   } ffsa_rsp_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_RSZ,
      S_SHDN,
      S_SHUP,
      S_DONE
   } ffsa_state_type;

endpackage

>>> rtl/ffsa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ffsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/first_fit_segment_allocator_core.sv
// A request settled at once goes straight to the response strobe; a resize that reads the
// tail passes through S_RSZ, a scan through S_SCAN, and a removal or insertion adds a shift
// of one entry per cycle in S_SHDN or S_SHUP. One request at a time; busy stays high
// through the response strobe, so the next request is accepted in the cycle after it at the
// earliest. A synchronous reset passes through S_INIT, which writes the initial segment.
// Depends on ffsa_pkg, ffsa_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "first_fit_segment_allocator_core_macros.svh"

module first_fit_segment_allocator_core
   import ffsa_pkg::*;
#(
   parameter int              MAX_SEGMENTS     = 32,
   parameter int              ADDR_BITS        = 32,
   parameter logic [63:0]     INITIAL_CAPACITY = 64'd2097152
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ffsa_req_type req_data,
   output logic         rsp_valid,
   output ffsa_rsp_type rsp_data
);

   localparam int A  = ADDR_BITS;
   localparam int EW = 2 * ADDR_BITS;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
   localparam logic [A-1:0]  INITC = A'(INITIAL_CAPACITY);

   ffsa_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [A-1:0]   cap_ff, cap_in;
   logic [1:0]     act_ff, act_in;
   logic [A-1:0]   off_ff, off_in, len_ff, len_in, want_ff, want_in;
   logic [A:0]     end_ff, end_in;
   logic [CW-1:0]  src_ff, src_in, left_ff, left_in, rq_ff, rq_in, at_ff, at_in;
   logic           rv_ff, rv_in;
   logic [EW-1:0]  prev_ff, prev_in, ins_ff, ins_in;
   logic [1:0]     st_ff, st_in;
   logic [A-1:0]   grant_ff, grant_in;

   logic           wr_en;
   logic [IW-1:0]  wr_addr, rd_addr;
   logic [EW-1:0]  wr_data, rd_data;
   logic           shift_rd;

   // segment table, entry = {start, size}
   ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [A-1:0]  e_start, e_size, p_start, p_size, r_off, r_len, r_want;
   logic [CW-1:0] cm1, nx;
   logic [A:0]    r_end, e_end, p_end;
   logic          hit, last, has_prev, tp, tn;

   assign e_start = rd_data[EW-1:A];
   assign e_size  = rd_data[A-1:0];
   assign e_end   = {1'b0, e_start} + {1'b0, e_size};
   assign cm1     = count_ff - CW'(1);
   assign r_off   = A'(req_data.offset);
   assign r_len   = A'(req_data.length);
   assign r_want  = A'(req_data.new_capacity);
   assign r_end   = {1'b0, r_off} + {1'b0, r_len};
   assign last    = (rq_ff + CW'(1)) == count_ff;

   // hit test and neighbor selection; for free, a hit places the range before the entry on rd_data
   always_comb begin
      if (act_ff == ACT_ALLOC) begin
         hit = e_size >= len_ff;
      end else begin
         hit = {1'b0, e_start} >= end_ff;
      end
      nx       = hit ? rq_ff : count_ff;
      has_prev = hit ? (rq_ff != '0) : 1'b1;
      p_start  = hit ? prev_ff[EW-1:A] : e_start;
      p_size   = hit ? prev_ff[A-1:0] : e_size;
      p_end    = {1'b0, p_start} + {1'b0, p_size};
      tp       = has_prev && (p_end == {1'b0, off_ff});
      tn       = hit && ({1'b0, e_start} == end_ff);
   end

   // sequencer: next state, ram control and result
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cap_in   = cap_ff;
      act_in   = act_ff;
      off_in   = off_ff;
      len_in   = len_ff;
      want_in  = want_ff;
      end_in   = end_ff;
      src_in   = src_ff;
      left_in  = left_ff;
      rq_in    = src_ff;
      at_in    = at_ff;
      rv_in    = 1'b0;
      prev_in  = prev_ff;
      ins_in   = ins_ff;
      st_in    = st_ff;
      grant_in = grant_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_addr  = src_ff[IW-1:0];
      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_data  = {{A{1'b0}}, cap_ff};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            rd_addr = cm1[IW-1:0];
            if (start) begin
               act_in   = req_data.action;
               off_in   = r_off;
               len_in   = r_len;
               want_in  = r_want;
               end_in   = r_end;
               src_in   = '0;
               grant_in = '0;
               st_in    = ST_OK;
               state_in = S_DONE;
               unique case (req_data.action)
                  ACT_ALLOC: begin
                     if (count_ff == '0) begin
                        st_in = ST_NOFIT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ACT_FREE: begin
                     if (r_len == '0 || r_end > {1'b0, cap_ff}) begin
                        state_in = S_DONE;
                     end else if (count_ff == '0) begin
                        ins_in   = {r_off, r_len};
                        at_in    = '0;
                        left_in  = '0;
                        state_in = S_SHUP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ACT_RESIZE: begin
                     if (r_want == cap_ff) begin
                        state_in = S_DONE;
                     end else if (count_ff == '0) begin
                        if (r_want > cap_ff) begin
                           wr_en    = 1'b1;
                           wr_data  = {cap_ff, r_want - cap_ff};
                           count_in = CW'(1);
                           cap_in   = r_want;
                        end else begin
                           st_in = ST_BADRESIZE;
                        end
                     end else begin
                        rv_in    = 1'b1;
                        state_in = S_RSZ;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // keep one read in flight ahead of the check
            if (src_ff < count_ff) begin
               rv_in  = 1'b1;
               src_in = src_ff + CW'(1);
            end
            if (rv_ff) begin
               if (act_ff == ACT_ALLOC) begin
                  if (hit) begin
                     grant_in = e_start;
                     rv_in    = 1'b0;
                     if (e_size == len_ff) begin
                        src_in   = rq_ff + CW'(1);
                        left_in  = cm1 - rq_ff;
                        state_in = S_SHDN;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = rq_ff[IW-1:0];
                        wr_data  = {e_start + len_ff, e_size - len_ff};
                        state_in = S_DONE;
                     end
                  end else if (last) begin
                     st_in    = ST_NOFIT;
                     rv_in    = 1'b0;
                     state_in = S_DONE;
                  end
               end else begin
                  prev_in = rd_data;
                  if (hit || last) begin
                     rv_in    = 1'b0;
                     state_in = S_DONE;
                     if (tp && tn) begin
                        wr_en    = 1'b1;
                        wr_addr  = IW'(nx - CW'(1));
                        wr_data  = {p_start, p_size + len_ff + e_size};
                        src_in   = nx + CW'(1);
                        left_in  = cm1 - nx;
                        state_in = S_SHDN;
                     end else if (tp) begin
                        wr_en   = 1'b1;
                        wr_addr = IW'(nx - CW'(1));
                        wr_data = {p_start, p_size + len_ff};
                     end else if (tn) begin
                        wr_en   = 1'b1;
                        wr_addr = nx[IW-1:0];
                        wr_data = {off_ff, e_size + len_ff};
                     end else if (count_ff == MAXC) begin
                        st_in = ST_FULL;
                     end else begin
                        ins_in   = {off_ff, len_ff};
                        at_in    = nx;
                        src_in   = cm1;
                        left_in  = count_ff - nx;
                        state_in = S_SHUP;
                     end
                  end
               end
            end
         end
         S_RSZ: begin
            state_in = S_DONE;
            wr_addr  = cm1[IW-1:0];
            if (want_ff > cap_ff) begin
               if (e_end == {1'b0, cap_ff}) begin
                  wr_en   = 1'b1;
                  wr_data = {e_start, want_ff - e_start};
                  cap_in  = want_ff;
               end else if (count_ff == MAXC) begin
                  st_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IW-1:0];
                  wr_data  = {cap_ff, want_ff - cap_ff};
                  count_in = count_ff + CW'(1);
                  cap_in   = want_ff;
               end
            end else if (e_end != {1'b0, cap_ff} || e_start > want_ff) begin
               st_in = ST_BADRESIZE;
            end else begin
               cap_in = want_ff;
               if (e_start == want_ff) begin
                  count_in = cm1;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {e_start, want_ff - e_start};
               end
            end
         end
         S_SHDN: begin
            // move entries one place toward the front
            if (left_ff != '0) begin
               rv_in   = 1'b1;
               src_in  = src_ff + CW'(1);
               left_in = left_ff - CW'(1);
            end
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(rq_ff - CW'(1));
               wr_data = rd_data;
            end else if (left_ff == '0) begin
               count_in = cm1;
               state_in = S_DONE;
            end
         end
         S_SHUP: begin
            // move entries one place toward the back, then place the new one
            if (left_ff != '0) begin
               rv_in   = 1'b1;
               src_in  = src_ff - CW'(1);
               left_in = left_ff - CW'(1);
            end
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(rq_ff + CW'(1));
               wr_data = rd_data;
            end else if (left_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = at_ff[IW-1:0];
               wr_data  = ins_ff;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= CW'(1);
         cap_ff   <= INITC;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
         rv_ff    <= rv_in;
      end
   end

   // request and working registers
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      off_ff   <= off_in;
      len_ff   <= len_in;
      want_ff  <= want_in;
      end_ff   <= end_in;
      src_ff   <= src_in;
      left_ff  <= left_in;
      rq_ff    <= rq_in;
      at_ff    <= at_in;
      prev_ff  <= prev_in;
      ins_ff   <= ins_in;
      st_ff    <= st_in;
      grant_ff <= grant_in;
   end

   // response
   assign busy                   = state_ff != S_IDLE;
   assign rsp_valid              = state_ff == S_DONE;
   assign rsp_data.status        = st_ff;
   assign rsp_data.alloc_offset  = 32'(grant_ff);
   assign rsp_data.free_segments = 6'(count_ff);

   // a shift step that also issues the next read
   assign shift_rd = rv_in && (state_ff == S_SHDN || state_ff == S_SHUP);

   `FFSA_ASSERT(a_count_bound, clock, reset, count_ff <= MAXC, "segment count above table size")
   `FFSA_IMPLIES(a_shift_no_alias, clock, reset, wr_en && shift_rd, wr_addr != rd_addr, "shift alias")
   `FFSA_IMPLIES_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy, "long response")
   `FFSA_IMPLIES_NEXT(a_busy_after_start, clock, reset, start && !busy, busy, "not busy after start")

endmodule

>>> tb/first_fit_segment_allocator_core_tb.sv
// self-checking testbench for the first-fit segment allocator core
// depends on ffsa_pkg and first_fit_segment_allocator_core
`timescale 1ns / 1ps

module first_fit_segment_allocator_core_tb;
   import ffsa_pkg::*;

   localparam int NSEG = 32;
   localparam logic [31:0] INIT_CAP = 32'd2097152;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   ffsa_req_type req_data;
   logic         rsp_valid;
   ffsa_rsp_type rsp_data;

   first_fit_segment_allocator_core u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // free segment table mirror
   logic [31:0] seg_base [NSEG];
   logic [31:0] seg_len [NSEG];
   int          seg_cnt;
   logic [31:0] buf_cap;

   ffsa_req_type pending_reqs[$];
   ffsa_rsp_type expected_rsps[$];
   int  error_count;
   int  rsp_count;
   int  cycle_count;
   int  sent_count;
   bit  drain_hold;
   bit  calm_phase;
   int  act_seen[4];

   function automatic void table_remove(int at);
      for (int i = at; i + 1 < seg_cnt; i++) begin
         seg_base[i] = seg_base[i + 1];
         seg_len[i] = seg_len[i + 1];
      end
      seg_cnt--;
   endfunction

   function automatic logic [1:0] table_insert(int at, logic [31:0] b, logic [31:0] l);
      if (seg_cnt >= NSEG) return ST_FULL;
      for (int i = seg_cnt; i > at; i--) begin
         seg_base[i] = seg_base[i - 1];
         seg_len[i] = seg_len[i - 1];
      end
      seg_base[at] = b;
      seg_len[at] = l;
      seg_cnt++;
      return ST_OK;
   endfunction

   // compute the response for one request and update the mirror
   function automatic ffsa_rsp_type alloc_predict(ffsa_req_type r);
      ffsa_rsp_type o;
      logic [1:0]   st;
      logic [31:0]  granted;
      logic [32:0]  fend;
      logic [32:0]  pend;
      int           nx;
      bit           tp, tn;
      int           lst;
      st = ST_OK;
      granted = '0;
      if (r.action == ACT_ALLOC) begin
         st = ST_NOFIT;
         for (int i = 0; i < seg_cnt; i++) begin
            if (seg_len[i] >= r.length) begin
               granted = seg_base[i];
               seg_base[i] = seg_base[i] + r.length;
               seg_len[i] = seg_len[i] - r.length;
               if (seg_len[i] == 0) table_remove(i);
               st = ST_OK;
               break;
            end
         end
      end else if (r.action == ACT_FREE) begin
         fend = {1'b0, r.offset} + r.length;
         if (r.length != 0 && fend <= {1'b0, buf_cap}) begin
            nx = 0;
            while (nx < seg_cnt && {1'b0, seg_base[nx]} < fend) nx++;
            tn = (nx < seg_cnt) && ({1'b0, seg_base[nx]} == fend);
            tp = 0;
            if (nx > 0) begin
               pend = {1'b0, seg_base[nx - 1]} + seg_len[nx - 1];
               tp = (pend == {1'b0, r.offset});
            end
            if (tp && tn) begin
               seg_len[nx - 1] = seg_len[nx - 1] + r.length + seg_len[nx];
               table_remove(nx);
            end else if (tp) begin
               seg_len[nx - 1] = seg_len[nx - 1] + r.length;
            end else if (tn) begin
               seg_base[nx] = r.offset;
               seg_len[nx] = seg_len[nx] + r.length;
            end else begin
               st = table_insert(nx, r.offset, r.length);
            end
         end
      end else if (r.action == ACT_RESIZE) begin
         lst = seg_cnt - 1;
         if (r.new_capacity > buf_cap) begin
            if (seg_cnt > 0 && {1'b0, seg_base[lst]} + seg_len[lst] == {1'b0, buf_cap}) begin
               seg_len[lst] = r.new_capacity - seg_base[lst];
               buf_cap = r.new_capacity;
            end else begin
               st = table_insert(seg_cnt, buf_cap, r.new_capacity - buf_cap);
               if (st == ST_OK) buf_cap = r.new_capacity;
            end
         end else if (r.new_capacity < buf_cap) begin
            if (seg_cnt == 0) begin
               st = ST_BADRESIZE;
            end else if ({1'b0, seg_base[lst]} + seg_len[lst] != {1'b0, buf_cap}
                         || seg_base[lst] > r.new_capacity) begin
               st = ST_BADRESIZE;
            end else begin
               if (seg_base[lst] == r.new_capacity) table_remove(lst);
               else seg_len[lst] = r.new_capacity - seg_base[lst];
               buf_cap = r.new_capacity;
            end
         end
      end
      o.status = st;
      o.alloc_offset = (st == ST_OK) ? granted : '0;
      o.free_segments = 6'(seg_cnt);
      return o;
   endfunction

   function automatic ffsa_req_type mk_req(logic [1:0] a, logic [31:0] off,
                                           logic [31:0] len, logic [31:0] cap);
      ffsa_req_type r;
      r.action = a;
      r.offset = off;
      r.length = len;
      r.new_capacity = cap;
      return r;
   endfunction

   // append one request to the stimulus queue
   function automatic void queue_req(ffsa_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // mostly small lengths, sometimes any 32-bit value
   function automatic logic [31:0] rand_len();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'($urandom_range(0, 3));
         2: return 32'h1 << $urandom_range(0, 31);
         default: return 32'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at response %0d: %s got %0h expected %0h",
               rsp_count, what, got, want);
      error_count++;
   endtask

   // request stimulus
   initial begin
      int          n;
      logic [31:0] off;
      queue_req(mk_req(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
      queue_req(mk_req(ACT_ALLOC, '0, 32'hFFFF_FFFF, '0));
      queue_req(mk_req(ACT_ALLOC, '0, 32'd100, '0));
      queue_req(mk_req(ACT_ALLOC, '0, 32'd200, '0));
      queue_req(mk_req(ACT_ALLOC, '0, 32'd300, '0));
      queue_req(mk_req(ACT_FREE, 32'd100, 32'd200, '0));
      queue_req(mk_req(ACT_FREE, 32'd0, 32'd100, '0));
      queue_req(mk_req(ACT_FREE, 32'd300, 32'd300, '0));
      queue_req(mk_req(ACT_FREE, 32'd50, 32'd0, '0));
      queue_req(mk_req(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
      queue_req(mk_req(ACT_FREE, 32'd10, 32'd20, '0));
      queue_req(mk_req(ACT_RESIZE, '0, '0, INIT_CAP));
      queue_req(mk_req(ACT_RESIZE, '0, '0, 32'hFFFF_FFFF));
      queue_req(mk_req(ACT_RESIZE, '0, '0, 32'h0020_0000));
      queue_req(mk_req(ACT_ALLOC, '0, 32'h0020_0000, '0));
      queue_req(mk_req(ACT_RESIZE, '0, '0, 32'd100));
      queue_req(mk_req(ACT_RESIZE, '0, '0, 32'h0030_0000));
      queue_req(mk_req(ACT_RESIZE, '0, '0, 32'h0020_0000));
      queue_req(mk_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_req(mk_req(ACT_ALLOC, '0, 32'h0020_0000, '0));
      queue_req(mk_req(ACT_ALLOC, '0, 32'd0, '0));
      queue_req(mk_req(ACT_RESIZE, '0, '0, 32'd0));
      queue_req(mk_req(ACT_RESIZE, '0, '0, INIT_CAP));
      // random mix: frees of small pieces fragment the table toward full
      n = 0;
      while (n < 1750) begin
         off = 32'($urandom_range(0, 1024)) * 32'd16;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
               queue_req(mk_req(ACT_ALLOC, $urandom(), rand_len(), $urandom()));
            6, 7, 8, 9, 10, 11, 12:
               queue_req(mk_req(ACT_FREE, off,
                  32'($urandom_range(1, 8)) * 32'd16, $urandom()));
            13:
               queue_req(mk_req(ACT_FREE, $urandom(), rand_len(), $urandom()));
            14, 15:
               queue_req(mk_req(ACT_RESIZE, $urandom(), $urandom(),
                  32'($urandom_range(32'h1F_0000, 32'h22_0000))));
            16:
               queue_req(mk_req(ACT_RESIZE, $urandom(), $urandom(), $urandom()));
            17:
               queue_req(mk_req(2'd3, $urandom(), $urandom(), $urandom()));
            default:
               queue_req(mk_req(ACT_ALLOC, $urandom(), 32'd16, $urandom()));
         endcase
         n++;
      end
   end

   // reset
   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         seg_cnt = 1;
         buf_cap = INIT_CAP;
         seg_base[0] = '0;
         seg_len[0] = INIT_CAP;
      end else if (!(start && busy)) begin
         if (start && !busy) begin
            // previous request accepted at this edge
            expected_rsps.insert(expected_rsps.size(), alloc_predict(req_data));
            act_seen[req_data.action]++;
            sent_count++;
         end
         if (sent_count == 300 && !drain_hold && start) drain_hold = 1'b1;
         if (drain_hold && expected_rsps.size() == 0 && !(start && !busy)) drain_hold = 1'b0;
         calm_phase = (sent_count > 800 && sent_count < 1000);
         if (pending_reqs.size() > 0 && !drain_hold &&
             (calm_phase || $urandom_range(0, 99) >= 18)) begin
            start <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
            req_data <= mk_req(2'($urandom()), $urandom(), $urandom(), $urandom());
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      ffsa_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected response %0d", rsp_count);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.alloc_offset !== want.alloc_offset)
               report_mismatch("alloc_offset", rsp_data.alloc_offset, want.alloc_offset);
            if (rsp_data.free_segments !== want.free_segments)
               report_mismatch("free_segments", 32'(rsp_data.free_segments),
                               32'(want.free_segments));
         end
         rsp_count++;
      end
   end

   // completion and timeout
   initial begin
      wait (!reset);
      while ((pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT || expected_rsps.size() > 0) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
      end else begin
         $display("covered %0d requests: %0d alloc, %0d free, %0d resize, %0d other",
                  sent_count, act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
         $display("checked %0d responses, %0d mismatches", rsp_count, error_count);
         if (error_count == 0) $display("*** PASSED ***");
         else $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_ram.sv
rtl/first_fit_segment_allocator_core.sv
tb/first_fit_segment_allocator_core_tb.sv
